// ===== src/microcoded_8bit_accumulator_cpu_defines.svh =====
// Assertion macros shared by the checker of the accumulator CPU.
`ifndef MICROCODED_8BIT_ACCUMULATOR_CPU_DEFINES_SVH
`define MICROCODED_8BIT_ACCUMULATOR_CPU_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MAC8_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MAC8_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/mac8cpu_pkg.sv =====
// Types, constants and encodings shared by the accumulator CPU modules.
package mac8cpu_pkg;

	// Data path and memory geometry.
	localparam int DATA_W    = 8;
	localparam int ADDR_W    = 8;
	localparam int MEM_DEPTH = 1 << ADDR_W;
	localparam int FLAG_W    = 3;
	localparam int STEP_W    = 3;

	// Stack and sequencer geometry.
	localparam int STACK_BASE      = 240;
	localparam int STACK_DEPTH     = 16;
	localparam int SP_W            = $clog2(STACK_DEPTH);
	localparam int STEPS_PER_INSTR = 6;

	// Item kinds on the command channel.
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	// Flag bit positions.
	localparam int FL_C_BIT = 0;
	localparam int FL_Z_BIT = 1;
	localparam int FL_N_BIT = 2;

	// Instruction encodings.
	localparam logic [DATA_W-1:0] OP_NUL = 8'd0;
	localparam logic [DATA_W-1:0] OP_HLT = 8'd1;
	localparam logic [DATA_W-1:0] OP_NOP = 8'd2;
	localparam logic [DATA_W-1:0] OP_LDA = 8'd3;
	localparam logic [DATA_W-1:0] OP_LDB = 8'd4;
	localparam logic [DATA_W-1:0] OP_JMP = 8'd5;
	localparam logic [DATA_W-1:0] OP_ADD = 8'd6;
	localparam logic [DATA_W-1:0] OP_SUB = 8'd7;
	localparam logic [DATA_W-1:0] OP_XOR = 8'd8;
	localparam logic [DATA_W-1:0] OP_AND = 8'd9;
	localparam logic [DATA_W-1:0] OP_OUT = 8'd10;
	localparam logic [DATA_W-1:0] OP_JPZ = 8'd11;
	localparam logic [DATA_W-1:0] OP_JPN = 8'd12;
	localparam logic [DATA_W-1:0] OP_JPC = 8'd13;
	localparam logic [DATA_W-1:0] OP_PSH = 8'd14;
	localparam logic [DATA_W-1:0] OP_POP = 8'd15;
	localparam logic [DATA_W-1:0] OP_JSR = 8'd16;
	localparam logic [DATA_W-1:0] OP_RSR = 8'd17;
	localparam logic [DATA_W-1:0] OP_MAB = 8'd18;
	localparam logic [DATA_W-1:0] OP_MBA = 8'd19;

	// One microcode control word.
	typedef struct packed {
		logic pc_in;
		logic pc_out;
		logic pc_inc;
		logic a_in;
		logic a_out;
		logic b_in;
		logic b_out;
		logic mar_in;
		logic mb_out;
		logic ir_in;
		logic halt;
		logic step0;
		logic alu_out;
		logic show;
		logic sp_inc;
		logic sp_dec;
		logic sp_out;
		logic write;
		logic mb_in;
	} ctrl_t;

	// Command item: program byte load or one clock tick.
	typedef struct packed {
		logic              opcode;
		logic [ADDR_W-1:0] address;
		logic [DATA_W-1:0] write_data;
	} cmd_t;

	// Result item, one per command item.
	typedef struct packed {
		logic              out_valid;
		logic [DATA_W-1:0] out_value;
		logic              halted;
		logic [DATA_W-1:0] acc_value;
		logic [FLAG_W-1:0] flag_bits;
	} rsp_t;

endpackage

// ===== src/mac8cpu_ucode.sv =====
// Microcode ROM: control word from instruction, micro-step and flags.
module mac8cpu_ucode (
	input  logic [mac8cpu_pkg::DATA_W-1:0] ir,
	input  logic [mac8cpu_pkg::STEP_W-1:0] step,
	input  logic [mac8cpu_pkg::FLAG_W-1:0] flags,
	output mac8cpu_pkg::ctrl_t             ctrl
);

	localparam logic [mac8cpu_pkg::STEP_W-1:0] T0 = 3'd0;
	localparam logic [mac8cpu_pkg::STEP_W-1:0] T1 = 3'd1;
	localparam logic [mac8cpu_pkg::STEP_W-1:0] T2 = 3'd2;
	localparam logic [mac8cpu_pkg::STEP_W-1:0] T3 = 3'd3;
	localparam logic [mac8cpu_pkg::STEP_W-1:0] T4 = 3'd4;
	localparam logic [mac8cpu_pkg::STEP_W-1:0] T5 = 3'd5;

	logic taken;

	// Jump condition for the conditional branches.
	always_comb begin
		unique case (ir) inside
			mac8cpu_pkg::OP_JPZ: taken = flags[mac8cpu_pkg::FL_Z_BIT];
			mac8cpu_pkg::OP_JPC: taken = flags[mac8cpu_pkg::FL_C_BIT];
			mac8cpu_pkg::OP_JPN: taken = flags[mac8cpu_pkg::FL_N_BIT];
			default:             taken = 1'b1;
		endcase
	end

	// Fetch steps are shared; later steps depend on the instruction.
	always_comb begin
		ctrl = '0;
		if (step == T0) begin
			ctrl.pc_out = 1'b1;
			ctrl.mar_in = 1'b1;
		end else if (step == T1) begin
			ctrl.mb_out = 1'b1;
			ctrl.ir_in  = 1'b1;
			ctrl.pc_inc = 1'b1;
		end else begin
			unique case (ir) inside
				mac8cpu_pkg::OP_NOP: begin
					ctrl.step0 = (step == T2);
				end
				mac8cpu_pkg::OP_HLT: begin
					ctrl.step0 = (step == T2);
					ctrl.halt  = (step == T2);
				end
				mac8cpu_pkg::OP_LDA, mac8cpu_pkg::OP_LDB: begin
					if (step == T2) begin
						ctrl.pc_out = 1'b1;
						ctrl.mar_in = 1'b1;
					end else if (step == T3) begin
						ctrl.mb_out = 1'b1;
						ctrl.mar_in = 1'b1;
						ctrl.pc_inc = 1'b1;
					end else if (step == T4) begin
						ctrl.mb_out = 1'b1;
						ctrl.step0  = 1'b1;
						ctrl.a_in   = (ir == mac8cpu_pkg::OP_LDA);
						ctrl.b_in   = (ir == mac8cpu_pkg::OP_LDB);
					end
				end
				mac8cpu_pkg::OP_JMP, mac8cpu_pkg::OP_JPZ, mac8cpu_pkg::OP_JPC,
				mac8cpu_pkg::OP_JPN: begin
					if (taken) begin
						if (step == T2) begin
							ctrl.pc_out = 1'b1;
							ctrl.mar_in = 1'b1;
						end else if (step == T3) begin
							ctrl.mb_out = 1'b1;
							ctrl.pc_in  = 1'b1;
							ctrl.step0  = 1'b1;
						end
					end else if (step == T2) begin
						ctrl.pc_inc = 1'b1;
						ctrl.step0  = 1'b1;
					end
				end
				mac8cpu_pkg::OP_ADD, mac8cpu_pkg::OP_SUB, mac8cpu_pkg::OP_XOR,
				mac8cpu_pkg::OP_AND: begin
					if (step == T2) begin
						ctrl.alu_out = 1'b1;
						ctrl.a_in    = 1'b1;
						ctrl.step0   = 1'b1;
					end
				end
				mac8cpu_pkg::OP_OUT: begin
					if (step == T2) begin
						ctrl.show  = 1'b1;
						ctrl.step0 = 1'b1;
					end
				end
				mac8cpu_pkg::OP_PSH: begin
					if (step == T2) begin
						ctrl.sp_out = 1'b1;
						ctrl.mar_in = 1'b1;
					end else if (step == T3) begin
						ctrl.a_out  = 1'b1;
						ctrl.mb_in  = 1'b1;
						ctrl.write  = 1'b1;
						ctrl.step0  = 1'b1;
						ctrl.sp_inc = 1'b1;
					end
				end
				mac8cpu_pkg::OP_POP: begin
					if (step == T2) begin
						ctrl.sp_dec = 1'b1;
					end else if (step == T3) begin
						ctrl.sp_out = 1'b1;
						ctrl.mar_in = 1'b1;
					end else if (step == T4) begin
						ctrl.a_in   = 1'b1;
						ctrl.mb_out = 1'b1;
						ctrl.step0  = 1'b1;
					end
				end
				mac8cpu_pkg::OP_JSR: begin
					if (step == T2) begin
						ctrl.sp_out = 1'b1;
						ctrl.mar_in = 1'b1;
					end else if (step == T3) begin
						ctrl.pc_out = 1'b1;
						ctrl.mb_in  = 1'b1;
						ctrl.write  = 1'b1;
						ctrl.sp_inc = 1'b1;
					end else if (step == T4) begin
						ctrl.pc_out = 1'b1;
						ctrl.mar_in = 1'b1;
					end else if (step == T5) begin
						ctrl.mb_out = 1'b1;
						ctrl.pc_in  = 1'b1;
						ctrl.step0  = 1'b1;
					end
				end
				mac8cpu_pkg::OP_RSR: begin
					if (step == T2) begin
						ctrl.sp_dec = 1'b1;
					end else if (step == T3) begin
						ctrl.sp_out = 1'b1;
						ctrl.mar_in = 1'b1;
					end else if (step == T4) begin
						ctrl.mb_out = 1'b1;
						ctrl.pc_in  = 1'b1;
						ctrl.pc_inc = 1'b1;
						ctrl.step0  = 1'b1;
					end
				end
				mac8cpu_pkg::OP_MAB: begin
					if (step == T2) begin
						ctrl.a_out = 1'b1;
						ctrl.b_in  = 1'b1;
						ctrl.step0 = 1'b1;
					end
				end
				mac8cpu_pkg::OP_MBA: begin
					if (step == T2) begin
						ctrl.b_out = 1'b1;
						ctrl.a_in  = 1'b1;
						ctrl.step0 = 1'b1;
					end
				end
				// NUL and undefined encodings leave the control word empty.
				default: begin
					ctrl = '0;
				end
			endcase
		end
	end

endmodule

// ===== src/mac8cpu_mem.sv =====
// Program memory with per-entry valid bits and the registered memory buffer.
module mac8cpu_mem (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           we,
	input  logic [mac8cpu_pkg::ADDR_W-1:0] waddr,
	input  logic [mac8cpu_pkg::DATA_W-1:0] wdata,
	input  logic                           re,
	input  logic [mac8cpu_pkg::ADDR_W-1:0] raddr,
	input  logic                           mb_load,
	input  logic [mac8cpu_pkg::DATA_W-1:0] mb_data,
	output logic [mac8cpu_pkg::DATA_W-1:0] mb
);

	logic [mac8cpu_pkg::DATA_W-1:0]    mem_q [mac8cpu_pkg::MEM_DEPTH];
	logic [mac8cpu_pkg::MEM_DEPTH-1:0] vld_q;
	logic [mac8cpu_pkg::DATA_W-1:0]    mb_q;

	// Storage array; a write and a read never fall in the same cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Valid bits make never-written entries read as zero after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (we) begin
			vld_q[waddr] <= 1'b1;
		end
	end

	// Memory buffer takes the read data, or the bus value on a write tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mb_q <= '0;
		end else if (re) begin
			mb_q <= vld_q[raddr] ? mem_q[raddr] : '0;
		end else if (mb_load) begin
			mb_q <= mb_data;
		end
	end

	assign mb = mb_q;

endmodule

// ===== src/microcoded_8bit_accumulator_cpu.sv =====
// Top level of the microcoded 8-bit accumulator CPU.
//
// Command channel (cmd_valid, cmd_ready, cmd): an item either loads one
// program byte (opcode load) or runs one CPU clock (opcode tick).
// Result channel (rsp_valid, rsp_ready, rsp): exactly one item per command
// item, in order, carrying the OUT strobe and value, the halt mark, the
// accumulator and the flags as they stand after that command.
// The result of a command accepted at one edge is offered from the next
// cycle on. Throughput is one item per cycle while results are taken; a
// tick executes one micro-step in the accepting cycle, with the microcode
// lookup, bus, register loads and the memory access issued together. The
// memory read lands in the memory buffer register at that same edge, so
// the next tick can follow at once.
// Reset clears all CPU registers and the memory valid bits, so the whole
// program memory reads as zero until written; a pending result item is dropped.
// When the receiver stalls, the result register holds its item and the
// command channel takes no new item until the result has been taken.
module microcoded_8bit_accumulator_cpu (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_ready,
	input  mac8cpu_pkg::cmd_t   cmd,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output mac8cpu_pkg::rsp_t   rsp
);

	localparam int DW = mac8cpu_pkg::DATA_W;
	localparam int FW = mac8cpu_pkg::FLAG_W;
	localparam int SW = mac8cpu_pkg::STEP_W;
	localparam int PW = mac8cpu_pkg::SP_W;

	// Architectural registers.
	logic [DW-1:0] acc_q, breg_q, pc_q, mar_q, bus_q, ir_q, alu_q;
	logic [SW-1:0] step_q;
	logic [FW-1:0] flags_q;
	logic [PW-1:0] sp_q;
	logic          halt_q;
	logic [DW-1:0] mb;

	// Result register.
	mac8cpu_pkg::rsp_t rsp_q;
	logic              rsp_valid_q;

	logic              accept, tick, load, mem_act;
	mac8cpu_pkg::ctrl_t ctrl, c;
	mac8cpu_pkg::rsp_t rsp_d;

	logic [DW-1:0] bus_n, acc_n, breg_n, pc_n, mar_n, ir_n, mb_n, alu_n;
	logic [SW-1:0] step_n;
	logic [FW-1:0] flags_n;
	logic [PW-1:0] sp_n;
	logic          halt_n;
	logic [DW:0]   sum;

	// Handshake: a new item enters when the result register is free or its item is taken.
	assign cmd_ready = !rsp_valid_q || rsp_ready;
	assign accept    = cmd_valid && cmd_ready;
	assign load      = accept && (cmd.opcode == mac8cpu_pkg::CMD_LOAD);
	assign tick      = accept && (cmd.opcode == mac8cpu_pkg::CMD_TICK) && !halt_q;

	mac8cpu_ucode u_ucode (
		.ir    (ir_q),
		.step  (step_q),
		.flags (flags_q),
		.ctrl  (ctrl)
	);

	// Control word applies only on a tick that runs.
	assign c       = tick ? ctrl : '0;
	assign mem_act = tick && !c.halt;

	// Bus source by fixed priority; the later source in the chain wins.
	always_comb begin
		bus_n = bus_q;
		if (c.pc_out)  bus_n = pc_q;
		if (c.mb_out)  bus_n = mb;
		if (c.a_out)   bus_n = acc_q;
		if (c.b_out)   bus_n = breg_q;
		if (c.alu_out) bus_n = alu_q;
		if (c.sp_out)  bus_n = DW'(mac8cpu_pkg::STACK_BASE) + DW'(sp_q);
	end

	// Register loads from the bus, then counters, step reset and halt.
	always_comb begin
		acc_n  = c.a_in   ? bus_n : acc_q;
		breg_n = c.b_in   ? bus_n : breg_q;
		mar_n  = c.mar_in ? bus_n : mar_q;
		ir_n   = c.ir_in  ? bus_n : ir_q;
		mb_n   = c.mb_in  ? bus_n : mb;
		pc_n   = c.pc_in  ? bus_n : pc_q;
		if (c.pc_inc) pc_n = pc_n + DW'(1);

		sp_n = sp_q;
		if (c.sp_inc) begin
			sp_n = (sp_n == PW'(mac8cpu_pkg::STACK_DEPTH - 1)) ? '0 : sp_n + PW'(1);
		end
		if (c.sp_dec) begin
			sp_n = (sp_n == '0) ? PW'(mac8cpu_pkg::STACK_DEPTH - 1) : sp_n - PW'(1);
		end

		step_n = (step_q == SW'(mac8cpu_pkg::STEPS_PER_INSTR - 1)) ? '0 : step_q + SW'(1);
		if (c.step0) begin
			step_n = '0;
			ir_n   = mac8cpu_pkg::OP_NUL;
		end
		halt_n = halt_q || c.halt;
	end

	// ALU acts on the instruction register value after this tick's loads.
	always_comb begin
		sum     = {1'b0, acc_n} + {1'b0, breg_n};
		alu_n   = alu_q;
		flags_n = flags_q;
		if (mem_act) begin
			case (ir_n)
				mac8cpu_pkg::OP_ADD: begin
					alu_n   = sum[DW-1:0];
					flags_n = '0;
					flags_n[mac8cpu_pkg::FL_C_BIT] = sum[DW];
				end
				mac8cpu_pkg::OP_SUB: begin
					alu_n   = acc_n - breg_n;
					flags_n = '0;
					flags_n[mac8cpu_pkg::FL_N_BIT] = (acc_n < breg_n);
				end
				mac8cpu_pkg::OP_XOR: begin
					alu_n   = acc_n ^ breg_n;
					flags_n = '0;
				end
				mac8cpu_pkg::OP_AND: begin
					alu_n   = acc_n & breg_n;
					flags_n = '0;
				end
				default: begin
					alu_n   = alu_q;
					flags_n = flags_q;
				end
			endcase
			if (ir_n == mac8cpu_pkg::OP_ADD || ir_n == mac8cpu_pkg::OP_SUB
				|| ir_n == mac8cpu_pkg::OP_XOR || ir_n == mac8cpu_pkg::OP_AND) begin
				flags_n[mac8cpu_pkg::FL_Z_BIT] = (alu_n == '0);
			end
		end
	end

	// Program memory: load items and write ticks write, other ticks but the halting one read.
	mac8cpu_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.we      (load || (mem_act && c.write)),
		.waddr   (load ? cmd.address : mar_n),
		.wdata   (load ? cmd.write_data : mb_n),
		.re      (mem_act && !c.write),
		.raddr   (mar_n),
		.mb_load (tick),
		.mb_data (mb_n),
		.mb      (mb)
	);

	// CPU register update on each running tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			breg_q  <= '0;
			pc_q    <= '0;
			mar_q   <= '0;
			bus_q   <= '0;
			ir_q    <= mac8cpu_pkg::OP_NUL;
			alu_q   <= '0;
			step_q  <= '0;
			flags_q <= '0;
			sp_q    <= '0;
			halt_q  <= 1'b0;
		end else if (tick) begin
			acc_q   <= acc_n;
			breg_q  <= breg_n;
			pc_q    <= pc_n;
			mar_q   <= mar_n;
			bus_q   <= bus_n;
			ir_q    <= ir_n;
			alu_q   <= alu_n;
			step_q  <= step_n;
			flags_q <= flags_n;
			sp_q    <= sp_n;
			halt_q  <= halt_n;
		end
	end

	// Result item built from the state after this item.
	always_comb begin
		rsp_d.out_valid = c.show;
		rsp_d.out_value = c.show ? acc_n : '0;
		rsp_d.halted    = halt_n;
		rsp_d.acc_value = acc_n;
		rsp_d.flag_bits = flags_n;
	end

	// Output register holds its item while the receiver stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== src/mac8cpu_checker.sv =====
// Port-level checker for the accumulator CPU and its bind to the top level.
`include "microcoded_8bit_accumulator_cpu_defines.svh"

module mac8cpu_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              cmd_valid,
	input logic              cmd_ready,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input mac8cpu_pkg::rsp_t rsp
);

	logic cmd_acc;

	assign cmd_acc = cmd_valid && cmd_ready;

	// Every accepted command yields a result item in the next cycle.
	`MAC8_ASSERT_NEXT(a_rsp_follows, clk, arst_n, cmd_acc, rsp_valid, "no result after command")

	// An empty result register never blocks the command channel.
	`MAC8_ASSERT_IMPL(a_ready_when_empty, clk, arst_n, !rsp_valid, cmd_ready, "stall with no result")

	// Without an OUT strobe the shown value is zero.
	`MAC8_ASSERT_IMPL(a_out_zero, clk, arst_n, rsp_valid && !rsp.out_valid, rsp.out_value == '0, "out_value set without OUT")

	// OUT shows the accumulator and never happens on a halted machine.
	`MAC8_ASSERT_IMPL(a_out_acc, clk, arst_n, rsp_valid && rsp.out_valid, (rsp.out_value == rsp.acc_value) && !rsp.halted, "OUT value mismatch")

	// A stalled result item holds.
	`MAC8_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "result changed while stalled")

endmodule

bind microcoded_8bit_accumulator_cpu mac8cpu_checker u_mac8cpu_checker (.*);

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the microcoded accumulator CPU: random programs, one status per item.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mac8cpu_pkg::*;

	// Architectural registers of one CPU copy.
	typedef struct packed {
		logic [DATA_W-1:0] acc;
		logic [DATA_W-1:0] breg;
		logic [DATA_W-1:0] pc;
		logic [DATA_W-1:0] mar;
		logic [DATA_W-1:0] mbr;
		logic [DATA_W-1:0] bus;
		logic [DATA_W-1:0] ir;
		logic [DATA_W-1:0] alu;
		logic [STEP_W-1:0] step;
		logic [FLAG_W-1:0] flags;
		logic [SP_W-1:0]   sp;
		logic              halt;
	} cpu_regs_t;

	// Two copies of the CPU: one steers the program generator, one predicts the results.
	localparam int PLAN_CPU   = 0;
	localparam int MIRROR_CPU = 1;
	localparam int PROGRAM_ITEMS = 1000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_ready;
	cmd_t cmd = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	cpu_regs_t         cpu_regs [2];
	logic [DATA_W-1:0] cpu_mem [2][MEM_DEPTH];
	cmd_t              cmds_to_send [$];
	rsp_t              status_due [$];
	int                mismatches = 0;
	logic              halt_armed = 1'b0;
	int                burst_left = 0;
	int                idle_left = 0;
	logic [15:0]       ready_cycle = '0;

	microcoded_8bit_accumulator_cpu uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always #10 clk = ~clk;

	// Control word for an instruction, micro-step and flag state.
	function automatic ctrl_t microcode_word(logic [DATA_W-1:0] op, logic [STEP_W-1:0] s,
			logic [FLAG_W-1:0] f);
		ctrl_t w;
		logic taken;
		w = '0;
		taken = 1'b0;
		if (s == 0) begin
			w.pc_out = 1'b1;
			w.mar_in = 1'b1;
		end else if (s == 1) begin
			w.mb_out = 1'b1;
			w.ir_in = 1'b1;
			w.pc_inc = 1'b1;
		end else begin
			case (op)
				OP_NOP: w.step0 = (s == 2);
				OP_HLT: if (s == 2) begin
					w.step0 = 1'b1;
					w.halt = 1'b1;
				end
				OP_LDA, OP_LDB: begin
					if (s == 2) begin
						w.pc_out = 1'b1;
						w.mar_in = 1'b1;
					end else if (s == 3) begin
						w.mb_out = 1'b1;
						w.mar_in = 1'b1;
						w.pc_inc = 1'b1;
					end else if (s == 4) begin
						w.mb_out = 1'b1;
						w.step0 = 1'b1;
						w.a_in = (op == OP_LDA);
						w.b_in = (op == OP_LDB);
					end
				end
				OP_JMP, OP_JPZ, OP_JPN, OP_JPC: begin
					taken = (op == OP_JMP) || (op == OP_JPZ && f[FL_Z_BIT])
						|| (op == OP_JPN && f[FL_N_BIT]) || (op == OP_JPC && f[FL_C_BIT]);
					if (taken && s == 2) begin
						w.pc_out = 1'b1;
						w.mar_in = 1'b1;
					end else if (taken && s == 3) begin
						w.mb_out = 1'b1;
						w.pc_in = 1'b1;
						w.step0 = 1'b1;
					end else if (!taken && s == 2) begin
						w.pc_inc = 1'b1;
						w.step0 = 1'b1;
					end
				end
				OP_ADD, OP_SUB, OP_XOR, OP_AND: if (s == 2) begin
					w.alu_out = 1'b1;
					w.a_in = 1'b1;
					w.step0 = 1'b1;
				end
				OP_OUT: if (s == 2) begin
					w.show = 1'b1;
					w.step0 = 1'b1;
				end
				OP_PSH: begin
					if (s == 2) begin
						w.sp_out = 1'b1;
						w.mar_in = 1'b1;
					end else if (s == 3) begin
						w.a_out = 1'b1;
						w.mb_in = 1'b1;
						w.write = 1'b1;
						w.step0 = 1'b1;
						w.sp_inc = 1'b1;
					end
				end
				OP_POP: begin
					if (s == 2) begin
						w.sp_dec = 1'b1;
					end else if (s == 3) begin
						w.sp_out = 1'b1;
						w.mar_in = 1'b1;
					end else if (s == 4) begin
						w.a_in = 1'b1;
						w.mb_out = 1'b1;
						w.step0 = 1'b1;
					end
				end
				OP_JSR: begin
					if (s == 2 || s == 4) begin
						w.sp_out = (s == 2);
						w.pc_out = (s == 4);
						w.mar_in = 1'b1;
					end else if (s == 3) begin
						w.pc_out = 1'b1;
						w.mb_in = 1'b1;
						w.write = 1'b1;
						w.sp_inc = 1'b1;
					end else if (s == 5) begin
						w.mb_out = 1'b1;
						w.pc_in = 1'b1;
						w.step0 = 1'b1;
					end
				end
				OP_RSR: begin
					if (s == 2) begin
						w.sp_dec = 1'b1;
					end else if (s == 3) begin
						w.sp_out = 1'b1;
						w.mar_in = 1'b1;
					end else if (s == 4) begin
						w.mb_out = 1'b1;
						w.pc_in = 1'b1;
						w.pc_inc = 1'b1;
						w.step0 = 1'b1;
					end
				end
				OP_MAB: if (s == 2) begin
					w.a_out = 1'b1;
					w.b_in = 1'b1;
					w.step0 = 1'b1;
				end
				OP_MBA: if (s == 2) begin
					w.b_out = 1'b1;
					w.a_in = 1'b1;
					w.step0 = 1'b1;
				end
				default: ;
			endcase
		end
		return w;
	endfunction

	// Apply one command item to CPU copy k and return the status it reports.
	function automatic rsp_t cpu_item(int k, cmd_t c);
		cpu_regs_t         r;
		ctrl_t             w;
		rsp_t              o;
		logic              shown;
		logic              alu_op;
		logic [DATA_W:0]   sum;
		logic [FLAG_W-1:0] fl;
		r = cpu_regs[k];
		shown = 1'b0;
		alu_op = 1'b0;
		fl = '0;
		if (c.opcode == CMD_LOAD) begin
			cpu_mem[k][c.address] = c.write_data;
		end else if (!r.halt) begin
			w = microcode_word(r.ir, r.step, r.flags);
			r.step = (r.step == STEP_W'(STEPS_PER_INSTR - 1)) ? '0 : r.step + 1'b1;

			// Bus source by priority, the last one wins.
			if (w.pc_out) r.bus = r.pc;
			if (w.mb_out) r.bus = r.mbr;
			if (w.a_out) r.bus = r.acc;
			if (w.b_out) r.bus = r.breg;
			if (w.alu_out) r.bus = r.alu;
			if (w.sp_out) r.bus = DATA_W'(STACK_BASE) + DATA_W'(r.sp);

			// Register loads from the bus.
			if (w.pc_in) r.pc = r.bus;
			if (w.a_in) r.acc = r.bus;
			if (w.b_in) r.breg = r.bus;
			if (w.mar_in) r.mar = r.bus;
			if (w.ir_in) r.ir = r.bus;
			if (w.mb_in) r.mbr = r.bus;

			// Counters, sequencer and the OUT strobe.
			if (w.pc_inc) r.pc = r.pc + 1'b1;
			if (w.sp_inc) r.sp = r.sp + 1'b1;
			if (w.sp_dec) r.sp = r.sp - 1'b1;
			if (w.step0) begin
				r.step = '0;
				r.ir = OP_NUL;
			end
			shown = w.show;

			// A halting tick skips the memory access and the ALU.
			if (w.halt) begin
				r.halt = 1'b1;
			end else begin
				if (w.write) cpu_mem[k][r.mar] = r.mbr;
				else r.mbr = cpu_mem[k][r.mar];
				case (r.ir)
					OP_ADD: begin
						sum = {1'b0, r.acc} + {1'b0, r.breg};
						r.alu = sum[DATA_W-1:0];
						fl[FL_C_BIT] = sum[DATA_W];
						alu_op = 1'b1;
					end
					OP_SUB: begin
						r.alu = r.acc - r.breg;
						fl[FL_N_BIT] = (r.acc < r.breg);
						alu_op = 1'b1;
					end
					OP_XOR: begin
						r.alu = r.acc ^ r.breg;
						alu_op = 1'b1;
					end
					OP_AND: begin
						r.alu = r.acc & r.breg;
						alu_op = 1'b1;
					end
					default: ;
				endcase
				if (alu_op) begin
					fl[FL_Z_BIT] = (r.alu == '0);
					r.flags = fl;
				end
			end
		end
		cpu_regs[k] = r;
		o.out_valid = shown;
		o.out_value = shown ? r.acc : '0;
		o.halted = r.halt;
		o.acc_value = r.acc;
		o.flag_bits = r.flags;
		return o;
	endfunction

	// Random instruction byte; HLT is kept out so that the program never stops early.
	function automatic logic [DATA_W-1:0] random_opcode();
		case ($urandom_range(0, 9))
			0: return OP_NUL;
			1: return DATA_W'($urandom_range(int'(OP_MBA) + 1, 255));
			default: return DATA_W'($urandom_range(int'(OP_NOP), int'(OP_MBA)));
		endcase
	endfunction

	// Random data byte with the extremes favored.
	function automatic logic [DATA_W-1:0] random_byte();
		if ($urandom_range(0, 3) == 0) return ($urandom_range(0, 1) == 1) ? 8'hff : 8'h00;
		return DATA_W'($urandom);
	endfunction

	// Queue a program byte write and follow it in the planning copy.
	task automatic send_load(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
		cmd_t c;
		c.opcode = CMD_LOAD;
		c.address = addr;
		c.write_data = data;
		void'(cpu_item(PLAN_CPU, c));
		cmds_to_send.push_back(c);
	endtask

	// Queue a clock tick. Before a fetch of HLT, the byte is replaced unless halting is wanted.
	task automatic send_tick();
		cmd_t c;
		if (!halt_armed && !cpu_regs[PLAN_CPU].halt && cpu_regs[PLAN_CPU].step == '0
				&& cpu_mem[PLAN_CPU][cpu_regs[PLAN_CPU].pc] == OP_HLT)
			send_load(cpu_regs[PLAN_CPU].pc, random_opcode());
		c.opcode = CMD_TICK;
		c.address = DATA_W'($urandom);
		c.write_data = DATA_W'($urandom);
		void'(cpu_item(PLAN_CPU, c));
		cmds_to_send.push_back(c);
	endtask

	// Report one field mismatch.
	task automatic check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			mismatches++;
		end
	endtask

	// Stimulus generation, reset and the end of the run.
	initial begin
		int n;
		logic [ADDR_W-1:0] at;
		logic [ADDR_W-1:0] base;
		logic [ADDR_W-1:0] where;
		logic [DATA_W-1:0] op;
		for (int k = 0; k < 2; k++) begin
			cpu_regs[k] = '0;
			for (int a = 0; a < MEM_DEPTH; a++) cpu_mem[k][a] = '0;
		end

		// Directed program: every instruction but HLT, both jump outcomes, a subroutine and the stack.
		send_load(8'd255, 8'hff);
		send_load(8'd254, 8'h01);
		send_load(8'd0, OP_LDA);
		send_load(8'd1, 8'd255);
		send_load(8'd2, OP_LDB);
		send_load(8'd3, 8'd254);
		send_load(8'd4, OP_ADD);
		send_load(8'd5, OP_JPZ);
		send_load(8'd6, 8'd9);
		send_load(8'd9, OP_JPC);
		send_load(8'd10, 8'd12);
		send_load(8'd12, OP_SUB);
		send_load(8'd13, OP_JPN);
		send_load(8'd14, 8'd16);
		send_load(8'd16, OP_OUT);
		send_load(8'd17, OP_XOR);
		send_load(8'd18, OP_JPZ);
		send_load(8'd20, OP_AND);
		send_load(8'd21, OP_PSH);
		send_load(8'd22, OP_MBA);
		send_load(8'd23, OP_MAB);
		send_load(8'd24, OP_JSR);
		send_load(8'd25, 8'd30);
		send_load(8'd26, OP_POP);
		send_load(8'd27, OP_JMP);
		send_load(8'd28, 8'd40);
		send_load(8'd30, OP_NOP);
		send_load(8'd31, 8'hc8);
		send_load(8'd32, OP_RSR);
		send_load(8'd40, OP_OUT);
		repeat (110) send_tick();

		// Random programs written at the current program counter, then run.
		while (cmds_to_send.size() < PROGRAM_ITEMS) begin
			n = $urandom_range(2, 10);
			base = cpu_regs[PLAN_CPU].pc;
			at = base;
			for (int i = 0; i < n; i++) begin
				op = random_opcode();
				send_load(at, op);
				at++;
				if (op inside {OP_LDA, OP_LDB}) begin
					where = DATA_W'($urandom);
					send_load(at, where);
					send_load(where, random_byte());
					at++;
				end else if (op inside {OP_JMP, OP_JPZ, OP_JPN, OP_JPC, OP_JSR}) begin
					if ($urandom_range(0, 3) == 0) send_load(at, DATA_W'($urandom));
					else send_load(at, base + DATA_W'($urandom_range(0, 2 * n)));
					at++;
				end
				// Stray writes anywhere in memory.
				if ($urandom_range(0, 9) == 0) send_load(DATA_W'($urandom), DATA_W'($urandom));
			end
			repeat ($urandom_range(3 * n, 8 * n)) send_tick();
		end

		// Finish with HLT, then show that ticks change nothing while writes still go in.
		while (cpu_regs[PLAN_CPU].step != '0) send_tick();
		halt_armed = 1'b1;
		send_load(cpu_regs[PLAN_CPU].pc, OP_HLT);
		repeat (6) send_tick();
		send_load(8'd0, 8'hff);
		send_load(8'd255, 8'h00);
		repeat (4) send_tick();

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (cmds_to_send.size() != 0 || cmd_valid) @(posedge clk);
		while (status_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// Timeout guard.
	initial begin
		#(10_000_000);
		$display("simulation failed");
		$finish;
	end

	// Command driver: bursts of items with idle gaps between them.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid <= 1'b0;
			burst_left <= 0;
			idle_left <= 0;
		end else if (!cmd_valid || cmd_ready) begin
			if (idle_left > 0) begin
				idle_left <= idle_left - 1;
				cmd_valid <= 1'b0;
			end else if (cmds_to_send.size() != 0) begin
				cmd <= cmds_to_send.pop_front();
				cmd_valid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 48);
					idle_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				cmd_valid <= 1'b0;
			end
		end
	end

	// Result receiver: cycles through always ready, random, sparse and long-stall phases.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			ready_cycle <= '0;
		end else begin
			ready_cycle <= ready_cycle + 1'b1;
			case (ready_cycle[9:8])
				2'd0: rsp_ready <= 1'b1;
				2'd1: rsp_ready <= ($urandom_range(0, 1) == 1);
				2'd2: rsp_ready <= (ready_cycle[2:0] == 3'd0);
				default: rsp_ready <= (ready_cycle[4:0] > 5'd20);
			endcase
		end
	end

	// Predict the status for each accepted command and compare each accepted result.
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n) begin
			if (cmd_valid && cmd_ready) status_due.push_back(cpu_item(MIRROR_CPU, cmd));
			if (rsp_valid && rsp_ready) begin
				if (status_due.size() == 0) begin
					$error("result item with no command outstanding: %p", rsp);
					mismatches++;
				end else begin
					want = status_due.pop_front();
					check_field("out_valid", want.out_valid, rsp.out_valid);
					check_field("out_value", want.out_value, rsp.out_value);
					check_field("halted", want.halted, rsp.halted);
					check_field("acc_value", want.acc_value, rsp.acc_value);
					check_field("flag_bits", want.flag_bits, rsp.flag_bits);
				end
			end
		end
	end

endmodule
